// ----- rtl/rsol_pkg.sv -----
// Shared constants, types and helper functions for the range sensor obstacle locator.
// Holds the sine polynomial coefficients, the field map limits and the register codes.
// No dependencies.
`default_nettype none

package rsol_pkg;

  // Angle and trig precision
  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int QUARTER_BITS   = ANGLE_BITS - 2;
  localparam int HEADING_W      = 16;

  // Q30 polynomial arithmetic
  localparam int Q30 = 30;
  localparam int Z_W = Q30 + 1;
  localparam logic [Z_W-1:0] ONE_Q30 = 31'd1073741824;
  localparam logic [30:0]    POLY_A  = 31'd1686629713;
  localparam logic [29:0]    POLY_B  = 30'd688904866;
  localparam logic [26:0]    POLY_C  = 27'd76016977;
  localparam logic [31:0]    RND_TRIG = 32'(1) << (Q30 - 1 - TRIG_FRAC_BITS);

  // Field widths
  localparam int DIST_W     = 12;
  localparam int POSE_W     = 12;
  localparam int MOUNT_W    = 10;
  localparam int NEAR_W     = 12;
  localparam int MARGIN_W   = 8;
  localparam int PX_W       = 13;
  localparam int TRIG_W     = TRIG_FRAC_BITS + 2;
  localparam int PROD_W     = PX_W + 1 + TRIG_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int POINT_W    = 16;
  localparam int OUT_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int NSTAGE     = 11;

  localparam logic signed [SUM_W-1:0] RND_POINT = SUM_W'(1) << (TRIG_FRAC_BITS - 1);

  // Register reset values
  localparam logic [MOUNT_W-1:0]  MOUNT_FORWARD_RST = 10'd145;
  localparam logic [MOUNT_W-1:0]  MOUNT_SIDE_RST    = 10'd75;
  localparam logic [NEAR_W-1:0]   NEAR_LIMIT_RST    = 12'd200;
  localparam logic [MARGIN_W-1:0] WALL_MARGIN_RST   = 8'd50;

  // Field map limits in mm
  localparam logic signed [POINT_W-1:0] RAMP_X_MIN   = 16'sd543;
  localparam logic signed [POINT_W-1:0] RAMP_Y_MIN   = -16'sd950;
  localparam logic signed [POINT_W-1:0] RAMP_Y_MAX   = 16'sd1050;
  localparam logic signed [POINT_W-1:0] SPIKE_X_MIN  = 16'sd400;
  localparam logic signed [POINT_W-1:0] SPIKE_X_MAX  = 16'sd600;
  localparam logic signed [POINT_W-1:0] SPIKE_Y_MIN  = -16'sd20;
  localparam logic signed [POINT_W-1:0] SPIKE_Y_MAX  = 16'sd20;
  localparam logic signed [POINT_W-1:0] ACCEL_X_MAX  = -16'sd934;
  localparam logic signed [POINT_W-1:0] ACCEL_Y_MIN  = -16'sd1000;
  localparam logic signed [POINT_W-1:0] ACCEL_Y_MAX  = 16'sd1000;
  localparam logic signed [POINT_W-1:0] BORDER_X     = 16'sd1000;
  localparam logic signed [POINT_W-1:0] BORDER_Y     = 16'sd1500;
  localparam logic signed [POINT_W-1:0] BORDER_WALL  = 16'sd30;

  // Output range and the no-target position
  localparam logic signed [POINT_W-1:0] OUT_MAX    = 16'sd4095;
  localparam logic signed [POINT_W-1:0] OUT_MIN    = -16'sd4096;
  localparam logic signed [OUT_W-1:0]   NONE_COORD = 13'sd2000;

  // Trig lanes
  localparam int LANE_SIN = 0;
  localparam int LANE_COS = 1;

  // Sensor slots
  localparam int SNS_RIGHT = 0;
  localparam int SNS_LEFT  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOUNT_FORWARD = 2'd0,
    REG_MOUNT_SIDE    = 2'd1,
    REG_NEAR_LIMIT    = 2'd2,
    REG_WALL_MARGIN   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SENSOR_NONE  = 2'd0,
    SENSOR_RIGHT = 2'd1,
    SENSOR_LEFT  = 2'd2
  } sensor_t;

  // Per-item side data that rides along the trig stages
  typedef struct packed {
    logic [1:0][DIST_W-1:0]  reading;
    logic [1:0][PX_W-1:0]    px;
    logic signed [POSE_W-1:0] pose_x;
    logic signed [POSE_W-1:0] pose_y;
  } carry_t;

  // True when the point lies on a known map feature, widened by the margin
  function automatic logic on_map(input logic signed [POINT_W-1:0] x,
                                  input logic signed [POINT_W-1:0] y,
                                  input logic [MARGIN_W-1:0] margin);
    logic signed [POINT_W-1:0] m;
    logic ramp, spike, accel, border;
    m = signed'(POINT_W'(margin));
    ramp   = (x > RAMP_X_MIN - m) && (y > RAMP_Y_MIN - m) && (y < RAMP_Y_MAX + m);
    spike  = (x > SPIKE_X_MIN - m) && (x < SPIKE_X_MAX + m) &&
             (y > SPIKE_Y_MIN - m) && (y < SPIKE_Y_MAX + m);
    accel  = (x < ACCEL_X_MAX + m) && (y > ACCEL_Y_MIN - m) && (y < ACCEL_Y_MAX + m);
    border = (x < -BORDER_X + BORDER_WALL + m) || (x > BORDER_X - BORDER_WALL - m) ||
             (y < -BORDER_Y + BORDER_WALL + m) || (y > BORDER_Y - BORDER_WALL - m);
    return ramp || spike || accel || border;
  endfunction

  // Clamp a point coordinate to the output range
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [POINT_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > OUT_MAX) begin
      r = OUT_W'(OUT_MAX);
    end else if (v < OUT_MIN) begin
      r = OUT_W'(OUT_MIN);
    end else begin
      r = OUT_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/range_sensor_obstacle_locator_core.sv -----
// Obstacle locator: places two range echoes on the field and picks the first off-map, near one.
// Depends on rsol_pkg for constants, map limits and helper functions.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per handshake: both range
//   readings, the heading as a binary angle and the robot position. Output channel
//   (out_valid / out_stall) returns exactly one result item per input item, in order:
//   found flag, which sensor, and the target position (2000, 2000 when none).
//   Configuration writes go over cfg_valid / cfg_ready with a register index and data;
//   cfg_ready is always high. Write registers only while no item is in flight.
//   Pipeline: eleven register stages. Throughput: one item per cycle while out_stall
//   is low; no stage chains more than one multiply (the sine polynomial takes four
//   chained Q30 products, then the rotation, rounding, map test and selection each
//   take their own stage).
//   Stall: when out_stall holds a waiting result, the stages behind it keep filling
//   bubbles; in_stall rises only when every stage holds an item. Nothing is dropped
//   or repeated.
//   Reset (rst, synchronous): empties the pipeline and loads the register defaults.
`default_nettype none

module range_sensor_obstacle_locator_core import rsol_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [DIST_W-1:0]           range_right,
  input  wire logic [DIST_W-1:0]           range_left,
  input  wire logic [HEADING_W-1:0]        heading,
  input  wire logic signed [POSE_W-1:0]    pose_x,
  input  wire logic signed [POSE_W-1:0]    pose_y,
  // output channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             found,
  output logic [1:0]                       which_sensor,
  output logic signed [OUT_W-1:0]          target_x,
  output logic signed [OUT_W-1:0]          target_y,
  // configuration channel
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data
);

  // Configuration registers
  logic [MOUNT_W-1:0]  mount_forward;
  logic [MOUNT_W-1:0]  mount_side;
  logic [NEAR_W-1:0]   near_limit;
  logic [MARGIN_W-1:0] wall_margin;

  // Pipeline control
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] go;

  // Side data shift line
  carry_t carry [NSTAGE-2];

  // Trig lanes
  logic [Z_W-1:0]  z0  [2];
  logic [Z_W-1:0]  z1  [2];
  logic [Z_W-1:0]  z2  [2];
  logic [Z_W-1:0]  z3  [2];
  logic [Z_W-1:0]  zsq1 [2];
  logic [Z_W-1:0]  zsq2 [2];
  logic [29:0]     t1_2 [2];
  logic [30:0]     t2_3 [2];
  logic [30:0]     s4   [2];
  logic [1:0]      neg;
  logic [1:0]      neg1;
  logic [1:0]      neg2;
  logic [1:0]      neg3;
  logic [1:0]      neg4;
  logic signed [TRIG_W-1:0] trig5 [2];

  // Polynomial products
  logic [61:0]     sq_prod [2];
  logic [56:0]     c_prod  [2];
  logic [59:0]     t_prod  [2];
  logic [61:0]     s_prod  [2];

  // Rotation and placement
  logic signed [PROD_W-1:0]  pc6 [2];
  logic signed [PROD_W-1:0]  ps6 [2];
  logic signed [PROD_W-1:0]  mc6;
  logic signed [PROD_W-1:0]  msn6;
  logic signed [SUM_W-1:0]   sx7 [2];
  logic signed [SUM_W-1:0]   sy7 [2];
  logic signed [POINT_W-1:0] tx8 [2];
  logic signed [POINT_W-1:0] ty8 [2];
  logic signed [POINT_W-1:0] tx9 [2];
  logic signed [POINT_W-1:0] ty9 [2];
  logic [1:0]                hit9;

  // Input stage combinational angle split
  logic [1:0]     quad;
  logic [Z_W-1:0] zfrac;
  logic [Z_W-1:0] zcomp;
  logic [31:0]    rnd_sum [2];
  logic [TRIG_FRAC_BITS:0] mag [2];

  // Configuration write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mount_forward <= MOUNT_FORWARD_RST;
      mount_side    <= MOUNT_SIDE_RST;
      near_limit    <= NEAR_LIMIT_RST;
      wall_margin   <= WALL_MARGIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MOUNT_FORWARD: mount_forward <= cfg_data[MOUNT_W-1:0];
        REG_MOUNT_SIDE:    mount_side    <= cfg_data[MOUNT_W-1:0];
        REG_NEAR_LIMIT:    near_limit    <= cfg_data[NEAR_W-1:0];
        REG_WALL_MARGIN:   wall_margin   <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    go[NSTAGE-1] = !vld[NSTAGE-1] || !out_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      go[k] = !vld[k] || go[k+1];
    end
  end

  assign in_stall  = !go[0];
  assign out_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (go[0]) vld[0] <= in_valid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (go[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Split the heading into quadrant and quarter-turn fraction
  assign quad  = heading[ANGLE_BITS-1 -: 2];
  assign zfrac = Z_W'(heading[QUARTER_BITS-1:0]) << (Q30 - QUARTER_BITS);
  assign zcomp = ONE_Q30 - zfrac;

  // Stage 0: pick polynomial arguments for sine and cosine
  always_ff @(posedge clk) begin
    if (go[0]) begin
      z0[LANE_SIN]             <= quad[0] ? zcomp : zfrac;
      z0[LANE_COS]             <= quad[0] ? zfrac : zcomp;
      neg[LANE_SIN]            <= quad[1];
      neg[LANE_COS]            <= quad[1] ^ quad[0];
    end
  end

  // Capture the side data and advance it
  always_ff @(posedge clk) begin
    if (go[0]) begin
      carry[0].reading[SNS_RIGHT] <= range_right;
      carry[0].reading[SNS_LEFT]  <= range_left;
      carry[0].px[SNS_RIGHT]      <= PX_W'(mount_forward) + PX_W'(range_right);
      carry[0].px[SNS_LEFT]       <= PX_W'(mount_forward) + PX_W'(range_left);
      carry[0].pose_x             <= pose_x;
      carry[0].pose_y             <= pose_y;
    end
    for (int k = 1; k < NSTAGE - 2; k++) begin
      if (go[k]) carry[k] <= carry[k-1];
    end
  end

  // Hold the sign flags alongside the trig lanes
  always_ff @(posedge clk) begin
    if (go[1]) neg1 <= neg;
    if (go[2]) neg2 <= neg1;
    if (go[3]) neg3 <= neg2;
    if (go[4]) neg4 <= neg3;
  end

  // Form one Q30 product per lane and stage
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sq_prod[l] = 62'(z0[l]) * 62'(z0[l]);
      c_prod[l]  = 57'(zsq1[l]) * 57'(POLY_C);
      t_prod[l]  = 60'(zsq2[l]) * 60'(t1_2[l]);
      s_prod[l]  = 62'(z3[l]) * 62'(t2_3[l]);
    end
  end

  // Stages 1 to 4: sine polynomial, one Q30 product per stage
  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (go[1]) begin
        zsq1[l] <= sq_prod[l][60:30];
        z1[l]   <= z0[l];
      end
      if (go[2]) begin
        t1_2[l] <= POLY_B - 30'(c_prod[l][56:30]);
        zsq2[l] <= zsq1[l];
        z2[l]   <= z1[l];
      end
      if (go[3]) begin
        t2_3[l] <= POLY_A - 31'(t_prod[l][59:30]);
        z3[l]   <= z2[l];
      end
      if (go[4]) begin
        s4[l] <= s_prod[l][60:30];
      end
    end
  end

  // Round the Q30 magnitude to the trig fraction
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rnd_sum[l] = 32'(s4[l]) + RND_TRIG;
      mag[l]     = rnd_sum[l][Q30 -: TRIG_FRAC_BITS + 1];
    end
  end

  // Stage 5: apply quadrant sign
  always_ff @(posedge clk) begin
    if (go[5]) begin
      for (int l = 0; l < 2; l++) begin
        trig5[l] <= neg4[l] ? -signed'({1'b0, mag[l]}) : signed'({1'b0, mag[l]});
      end
    end
  end

  // Stage 6: rotation products
  always_ff @(posedge clk) begin
    if (go[6]) begin
      for (int i = 0; i < 2; i++) begin
        pc6[i] <= PROD_W'(signed'({1'b0, carry[5].px[i]})) * PROD_W'(trig5[LANE_COS]);
        ps6[i] <= PROD_W'(signed'({1'b0, carry[5].px[i]})) * PROD_W'(trig5[LANE_SIN]);
      end
      mc6  <= PROD_W'(signed'({1'b0, mount_side})) * PROD_W'(trig5[LANE_COS]);
      msn6 <= PROD_W'(signed'({1'b0, mount_side})) * PROD_W'(trig5[LANE_SIN]);
    end
  end

  // Stage 7: rotated sums with the rounding half added
  always_ff @(posedge clk) begin
    if (go[7]) begin
      sx7[SNS_RIGHT] <= SUM_W'(pc6[SNS_RIGHT]) - SUM_W'(msn6) + RND_POINT;
      sy7[SNS_RIGHT] <= -SUM_W'(mc6) - SUM_W'(ps6[SNS_RIGHT]) + RND_POINT;
      sx7[SNS_LEFT]  <= SUM_W'(pc6[SNS_LEFT]) + SUM_W'(msn6) + RND_POINT;
      sy7[SNS_LEFT]  <= SUM_W'(mc6) - SUM_W'(ps6[SNS_LEFT]) + RND_POINT;
    end
  end

  // Stage 8: drop the fraction, offset by the robot position
  always_ff @(posedge clk) begin
    if (go[8]) begin
      for (int i = 0; i < 2; i++) begin
        tx8[i] <= POINT_W'(sx7[i] >>> TRIG_FRAC_BITS) + POINT_W'(carry[7].pose_x);
        ty8[i] <= POINT_W'(sy7[i] >>> TRIG_FRAC_BITS) + POINT_W'(carry[7].pose_y);
      end
    end
  end

  // Stage 9: map test and near check
  always_ff @(posedge clk) begin
    if (go[9]) begin
      for (int i = 0; i < 2; i++) begin
        hit9[i] <= !on_map(tx8[i], ty8[i], wall_margin) &&
                   (carry[8].reading[i] < near_limit);
        tx9[i]  <= tx8[i];
        ty9[i]  <= ty8[i];
      end
    end
  end

  // Stage 10: pick right then left, saturate into the output register
  always_ff @(posedge clk) begin
    if (go[10]) begin
      if (hit9[SNS_RIGHT]) begin
        found        <= 1'b1;
        which_sensor <= SENSOR_RIGHT;
        target_x     <= sat_out(tx9[SNS_RIGHT]);
        target_y     <= sat_out(ty9[SNS_RIGHT]);
      end else if (hit9[SNS_LEFT]) begin
        found        <= 1'b1;
        which_sensor <= SENSOR_LEFT;
        target_x     <= sat_out(tx9[SNS_LEFT]);
        target_y     <= sat_out(ty9[SNS_LEFT]);
      end else begin
        found        <= 1'b0;
        which_sensor <= SENSOR_NONE;
        target_x     <= NONE_COORD;
        target_y     <= NONE_COORD;
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for range_sensor_obstacle_locator_core: directed and random sensor
// items under several register settings, each result checked against a local predictor.
// Depends on rsol_pkg and the core RTL.

module tb_top;
  import rsol_pkg::*;

  localparam int WATCHDOG_LIMIT = 1500;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 120;
  localparam int HOLD_AT_FIRST  = 90;
  localparam int HOLD_AT_SECOND = 380;
  localparam int MAX_REPORTS    = 10;

  // sine polynomial coefficients, Q30
  localparam longint COEF_A  = 64'd1686629713;
  localparam longint COEF_B  = 64'd688904866;
  localparam longint COEF_C  = 64'd76016977;
  localparam longint UNIT_Q30 = 64'd1073741824;
  localparam logic [HEADING_W-1:0] QUARTER_TURN = 16'd16384;

  // field map, mm
  localparam longint RAMP_LO_X   = 543;
  localparam longint RAMP_LO_Y   = -950;
  localparam longint RAMP_HI_Y   = 1050;
  localparam longint SPIKE_LO_X  = 400;
  localparam longint SPIKE_HI_X  = 600;
  localparam longint SPIKE_LO_Y  = -20;
  localparam longint SPIKE_HI_Y  = 20;
  localparam longint ACCEL_HI_X  = -934;
  localparam longint ACCEL_LO_Y  = -1000;
  localparam longint ACCEL_HI_Y  = 1000;
  localparam longint FIELD_HALF_X = 1000;
  localparam longint FIELD_HALF_Y = 1500;
  localparam longint WALL_DEPTH  = 30;
  localparam longint NO_TARGET   = 2000;

  typedef struct {
    logic [DIST_W-1:0]        right;
    logic [DIST_W-1:0]        left;
    logic [HEADING_W-1:0]     angle;
    logic signed [POSE_W-1:0] x;
    logic signed [POSE_W-1:0] y;
  } scan_t;

  typedef struct {
    logic                    found;
    sensor_t                 which;
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
  } sighting_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [DIST_W-1:0]        range_right = '0;
  logic [DIST_W-1:0]        range_left = '0;
  logic [HEADING_W-1:0]     heading = '0;
  logic signed [POSE_W-1:0] pose_x = '0;
  logic signed [POSE_W-1:0] pose_y = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     found;
  logic [1:0]               which_sensor;
  logic signed [OUT_W-1:0]  target_x;
  logic signed [OUT_W-1:0]  target_y;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  // register copy used by the predictor
  logic [MOUNT_W-1:0]  fwd_mm    = MOUNT_FORWARD_RST;
  logic [MOUNT_W-1:0]  side_mm   = MOUNT_SIDE_RST;
  logic [NEAR_W-1:0]   near_mm   = NEAR_LIMIT_RST;
  logic [MARGIN_W-1:0] margin_mm = WALL_MARGIN_RST;

  scan_t     queued_scans[$];
  sighting_t due_sightings[$];

  int  mismatches = 0;
  int  gap_left = 0;
  int  sent_count = 0;
  bit  send_calm = 1'b0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  taken_count = 0;
  int  recv_calm_left = 0;
  bit  recv_calm = 1'b0;
  int  idle_cycles = 0;

  range_sensor_obstacle_locator_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .range_right  (range_right),
    .range_left   (range_left),
    .heading      (heading),
    .pose_x       (pose_x),
    .pose_y       (pose_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .which_sensor (which_sensor),
    .target_x     (target_x),
    .target_y     (target_y),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sine of a quarter-turn fraction, Q30 in and out; every product truncates
  function automatic longint quarter_sine_q30(input longint z);
    longint z2, t;
    z2 = (z * z) >>> 30;
    t  = COEF_B - ((z2 * COEF_C) >>> 30);
    t  = COEF_A - ((z2 * t) >>> 30);
    return (z * t) >>> 30;
  endfunction

  // Signed sine in Q14 of a binary angle
  function automatic longint sine_q14(input logic [HEADING_W-1:0] angle);
    logic [1:0] quad;
    longint z, s;
    quad = angle[HEADING_W-1 -: 2];
    z = longint'(angle[HEADING_W-3:0]) << (30 - (HEADING_W - 2));
    if (quad[0]) z = UNIT_Q30 - z;
    s = (quarter_sine_q30(z) + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    return quad[1] ? -s : s;
  endfunction

  // Q14 to whole mm, halves going up
  function automatic longint round_mm(input longint v);
    return (v + (longint'(1) << (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
  endfunction

  function automatic bit hits_field_map(input longint x, input longint y, input longint m);
    bit ramp, spike, accel, border;
    ramp   = x > RAMP_LO_X - m && y > RAMP_LO_Y - m && y < RAMP_HI_Y + m;
    spike  = x > SPIKE_LO_X - m && x < SPIKE_HI_X + m && y > SPIKE_LO_Y - m &&
             y < SPIKE_HI_Y + m;
    accel  = x < ACCEL_HI_X + m && y > ACCEL_LO_Y - m && y < ACCEL_HI_Y + m;
    border = x < -FIELD_HALF_X + WALL_DEPTH + m || x > FIELD_HALF_X - WALL_DEPTH - m ||
             y < -FIELD_HALF_Y + WALL_DEPTH + m || y > FIELD_HALF_Y - WALL_DEPTH - m;
    return ramp || spike || accel || border;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp13(input longint v);
    if (v > 4095) v = 4095;
    if (v < -4096) v = -4096;
    return OUT_W'(v);
  endfunction

  // Place both echoes on the field and keep the first one that is off the map and near
  function automatic sighting_t locate_obstacle(input scan_t s);
    longint sn, cs, px, py, tx, ty;
    logic [DIST_W-1:0] d;
    sighting_t r;
    sn = sine_q14(s.angle);
    cs = sine_q14(HEADING_W'(s.angle + QUARTER_TURN));
    r.found = 1'b0;
    r.which = SENSOR_NONE;
    r.x = OUT_W'(NO_TARGET);
    r.y = OUT_W'(NO_TARGET);
    for (int k = 0; k < 2; k++) begin
      if (!r.found) begin
        d  = (k == 0) ? s.right : s.left;
        py = (k == 0) ? -longint'(side_mm) : longint'(side_mm);
        px = longint'(fwd_mm) + longint'(d);
        tx = round_mm(px * cs + py * sn) + longint'(s.x);
        ty = round_mm(py * cs - px * sn) + longint'(s.y);
        if (!hits_field_map(tx, ty, longint'(margin_mm)) && d < near_mm) begin
          r.found = 1'b1;
          if (k == 0) r.which = SENSOR_RIGHT;
          else r.which = SENSOR_LEFT;
          r.x = clamp13(tx);
          r.y = clamp13(ty);
        end
      end
    end
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap(input int zero_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Reading: mostly short, some right at the near limit, some anywhere
  function automatic logic [DIST_W-1:0] pick_range();
    int r, v;
    r = $urandom_range(0, 9);
    if (r < 5) v = $urandom_range(0, 400);
    else if (r < 7) v = int'(near_mm) + int'($urandom_range(0, 4)) - 2;
    else v = $urandom_range(0, 4095);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return DIST_W'(v);
  endfunction

  task automatic queue_scan(input int r, input int l, input int h, input int x, input int y);
    scan_t sc;
    sc.right = DIST_W'(r);
    sc.left  = DIST_W'(l);
    sc.angle = HEADING_W'(h);
    sc.x     = POSE_W'(x);
    sc.y     = POSE_W'(y);
    queued_scans.push_back(sc);
  endtask

  // Most items sit on the field with short readings, the rest are raw noise
  task automatic queue_random(input int count);
    scan_t sc;
    @(negedge clk);
    repeat (count) begin
      if ($urandom_range(0, 9) < 4) begin
        sc.right = DIST_W'($urandom);
        sc.left  = DIST_W'($urandom);
        sc.angle = HEADING_W'($urandom);
        sc.x     = POSE_W'($urandom);
        sc.y     = POSE_W'($urandom);
      end else begin
        sc.right = pick_range();
        sc.left  = pick_range();
        sc.angle = HEADING_W'($urandom);
        sc.x     = POSE_W'(int'($urandom_range(0, 1500)) - 950);
        sc.y     = POSE_W'(int'($urandom_range(0, 2900)) - 1450);
      end
      queued_scans.push_back(sc);
    end
  endtask

  // Hold until every item has left the block, then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk);
    while (queued_scans.size() != 0 || in_valid || due_sightings.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MOUNT_FORWARD: fwd_mm    = val[MOUNT_W-1:0];
      REG_MOUNT_SIDE:    side_mm   = val[MOUNT_W-1:0];
      REG_NEAR_LIMIT:    near_mm   = val[NEAR_W-1:0];
      REG_WALL_MARGIN:   margin_mm = val[MARGIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int fwd, input int side, input int near, input int margin);
    write_reg(REG_MOUNT_FORWARD, CFG_DATA_W'(fwd));
    write_reg(REG_MOUNT_SIDE, CFG_DATA_W'(side));
    write_reg(REG_NEAR_LIMIT, CFG_DATA_W'(near));
    write_reg(REG_WALL_MARGIN, CFG_DATA_W'(margin));
  endtask

  // Stimulus: directed items at reset values, then random items under several settings
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    queue_scan(100, 100, 0, 0, 0);            // right sensor sees the opponent
    queue_scan(300, 100, 0, 0, 0);            // right too far, left taken
    queue_scan(100, 100, 0, 300, 0);          // both echoes on the ramp
    queue_scan(0, 0, 0, 0, 0);
    queue_scan(4095, 4095, 65535, 2047, 2047);
    queue_scan(4095, 4095, 0, -2048, -2048);
    queue_scan(199, 199, 16384, 0, 0);        // just under the near limit
    queue_scan(200, 150, 32768, 0, 0);        // right exactly at the limit
    queue_scan(150, 150, 49152, -500, 600);
    queue_scan(50, 50, 8192, -2048, 0);
    queue_scan(50, 50, 24576, 0, 1400);       // near the far border wall
    queue_scan(100, 4095, 0, 2047, -2048);
    queue_scan(0, 199, 40960, -900, -1400);
    queue_scan(120, 80, 0, -100, -1000);
    queue_scan(0, 0, 65535, 0, 0);
    queue_scan(4095, 0, 0, 0, 0);             // left only
    queue_scan(180, 180, 12000, 250, -30);    // close to the spike
    queue_scan(10, 10, 32768, 900, 100);
    queue_scan(60, 60, 5461, -300, 300);
    queue_scan(4095, 4095, 32768, -2048, 2047);
    queue_random(150);

    wait_idle();
    apply_setting(1023, 1023, 4095, 255);
    queue_random(100);

    wait_idle();
    apply_setting(0, 0, 0, 0);
    queue_random(100);

    wait_idle();
    apply_setting(0, 0, 4095, 0);
    queue_random(150);

    // random setting; spare upper data bits set to show they are dropped
    wait_idle();
    apply_setting($urandom_range(0, 400) | ($urandom_range(0, 3) << MOUNT_W),
                  $urandom_range(0, 300) | ($urandom_range(0, 3) << MOUNT_W),
                  $urandom_range(100, 1500),
                  $urandom_range(0, 255) | ($urandom_range(0, 15) << MARGIN_W));
    queue_random(150);

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Sender: log each item the block takes, then offer the next after any gap
  always @(posedge clk) begin
    scan_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_sightings.push_back(locate_obstacle(
          scan_t'{range_right, range_left, heading, pose_x, pose_y}));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (queued_scans.size() != 0) begin
          nxt = queued_scans.pop_front();
          range_right <= nxt.right;
          range_left  <= nxt.left;
          heading     <= nxt.angle;
          pose_x      <= nxt.x;
          pose_y      <= nxt.y;
          in_valid    <= 1'b1;
          sent_count++;
          if (sent_count % 30 == 0) send_calm = ($urandom_range(0, 3) == 0);
          gap_left = send_calm ? 0 : pick_gap(60);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, calm stretches, and two long holds to back the block up
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        taken_count++;
        if (taken_count == HOLD_AT_FIRST || taken_count == HOLD_AT_SECOND)
          hold_left = HOLD_CYCLES;
      end
      if (recv_calm_left == 0) begin
        recv_calm = ($urandom_range(0, 3) == 0);
        recv_calm_left = 40;
      end else begin
        recv_calm_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = recv_calm ? 0 : pick_gap(70);
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every result taken with the oldest prediction
  always @(posedge clk) begin
    sighting_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_sightings.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected item: found=%0d which=%0d x=%0d y=%0d",
                   found, which_sensor, target_x, target_y);
      end else begin
        want = due_sightings.pop_front();
        if (found !== want.found || which_sensor !== want.which ||
            target_x !== want.x || target_y !== want.y) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: want found=%0d which=%0d x=%0d y=%0d, got found=%0d which=%0d x=%0d y=%0d",
                     want.found, want.which, want.x, want.y,
                     found, which_sensor, target_x, target_y);
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

endmodule
